[rtl/tmpf_pkg.sv]
// Shared types, constants and helper functions of the tile-map pixel fetch block.
`default_nettype none

package tmpf_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int TILE_DIM    = 32;                     // power of two
	localparam int TILE_W      = $clog2(TILE_DIM);
	localparam int ENTRY_W     = $clog2(MAX_ENTRIES);
	localparam int TILE_ADDR_W = ENTRY_W + 2 * TILE_W;
	localparam int TILE_DEPTH  = MAX_ENTRIES * TILE_DIM * TILE_DIM;

	localparam int COORD_W = 13;
	localparam int GRID_W  = COORD_W - TILE_W;
	localparam int CFG8_W  = 8;
	localparam int CNT_W   = 9;
	localparam int ROW_W   = CFG8_W + 1;
	localparam int IDX_W   = ROW_W + CFG8_W;
	localparam int TNUM_W  = 16;
	localparam int PIX_W   = 8;
	localparam int PXC_W   = 5;
	localparam int CELL_W  = 8;
	localparam int LIVE_MAX = (MAX_ENTRIES < 511) ? MAX_ENTRIES : 511;

	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CRD_W      = $clog2(FIFO_DEPTH + 1);

	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [1:0] {
		OP_CELL_WR = 2'd0,
		OP_TILE_WR = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GRID_COLUMNS = 3'd0,
		REG_GRID_ROWS    = 3'd1,
		REG_ENTRY_COUNT  = 3'd2,
		REG_SLICE_LEFT   = 3'd3,
		REG_SLICE_TOP    = 3'd4,
		REG_SLICE_COLS   = 3'd5,
		REG_SLICE_ROWS   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [CFG8_W-1:0] grid_columns;
		logic [CFG8_W-1:0] grid_rows;
		logic [CNT_W-1:0]  entry_count;
		logic [CFG8_W-1:0] slice_left;
		logic [CFG8_W-1:0] slice_top;
		logic [CFG8_W-1:0] slice_cols;
		logic [CFG8_W-1:0] slice_rows;
	} cfg_t;

	typedef struct packed {
		op_t                op;
		logic [CELL_W-1:0]  cell_number;
		logic [TNUM_W-1:0]  tile_number;
		logic [PXC_W-1:0]   tile_px_x;
		logic [PXC_W-1:0]   tile_px_y;
		logic [PIX_W-1:0]   pixel_value;
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
	} req_t;

	// per-item control and payload moving down the pipe
	typedef struct packed {
		logic               rd;
		logic               cell_we;
		logic               tile_we;
		logic               slice_ok;
		logic               look;
		logic [ENTRY_W-1:0] cell_addr;
		logic [TNUM_W-1:0]  tile_number;
		logic [TILE_W-1:0]  px;
		logic [TILE_W-1:0]  py;
		logic [PIX_W-1:0]   pixel_value;
	} stage_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             covered;
		logic             slice_valid;
	} res_t;

	function automatic logic slice_ok(cfg_t c);
		logic [ROW_W-1:0] right;
		logic [ROW_W-1:0] bottom;
		right  = ROW_W'(c.slice_left) + ROW_W'(c.slice_cols);
		bottom = ROW_W'(c.slice_top) + ROW_W'(c.slice_rows);
		return (c.slice_cols != '0) && (c.slice_rows != '0) &&
			(right <= ROW_W'(c.grid_columns)) && (bottom <= ROW_W'(c.grid_rows));
	endfunction

	function automatic logic [CNT_W-1:0] live_count(cfg_t c);
		return (32'(c.entry_count) > LIVE_MAX) ? CNT_W'(LIVE_MAX) : c.entry_count;
	endfunction

endpackage

`default_nettype wire

[rtl/tmpf_if.sv]
// Handshake interfaces for the request, result and configuration channels.
`default_nettype none

interface tmpf_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    op;
	logic [tmpf_pkg::CELL_W-1:0]   cell_number;
	logic [tmpf_pkg::TNUM_W-1:0]   tile_number;
	logic [tmpf_pkg::PXC_W-1:0]    tile_px_x;
	logic [tmpf_pkg::PXC_W-1:0]    tile_px_y;
	logic [tmpf_pkg::PIX_W-1:0]    pixel_value;
	logic [tmpf_pkg::COORD_W-1:0]  out_x;
	logic [tmpf_pkg::COORD_W-1:0]  out_y;

	modport source (
		output valid, op, cell_number, tile_number, tile_px_x, tile_px_y,
			pixel_value, out_x, out_y,
		input  ready
	);
	modport sink (
		input  valid, op, cell_number, tile_number, tile_px_x, tile_px_y,
			pixel_value, out_x, out_y,
		output ready
	);
endinterface

interface tmpf_out_if;
	logic                        valid;
	logic                        ready;
	logic [tmpf_pkg::PIX_W-1:0]  pixel_out;
	logic                        covered;
	logic                        slice_valid;

	modport source (output valid, pixel_out, covered, slice_valid, input ready);
	modport sink (input valid, pixel_out, covered, slice_valid, output ready);
endinterface

interface tmpf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tmpf_pkg::REG_IDX_W-1:0]    index;
	logic [tmpf_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/tile_map_pixel_fetch.sv]
// Top level of the tile-map pixel fetch block: config registers and pipeline.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------------------
//  cfg     | in  | index (3b), data (9b)
//  req     | in  | op, cell_number, tile_number, tile_px_x/y, pixel_value, out_x/y
//  rsp     | out | pixel_out, covered, slice_valid
//
// One request beat per cycle while result queue credits remain; a read result passes
// decode, index multiply, cell store read, tile store read and result queue write
// before it appears on rsp.
// Up to eight reads may be outstanding; req.ready drops once the result queue
// credits run out and comes back as rsp beats are taken.
// Config writes are always accepted (cfg.ready is tied high). Reset clears config
// and pipeline control; both stores hold garbage until written.
`default_nettype none

module tile_map_pixel_fetch (
	input  logic              clk,
	input  logic              arst_n,
	tmpf_cfg_if.sink          cfg,
	tmpf_in_if.sink           req,
	tmpf_out_if.source        rsp
);

	tmpf_pkg::cfg_t                cfg_q;
	tmpf_pkg::req_t                req_pl;
	logic                          take;
	logic                          can_take;
	logic                          vld_s2;
	tmpf_pkg::stage_t              st_s2;
	logic [tmpf_pkg::IDX_W-1:0]    idx_s2;
	logic                          res_vld;
	tmpf_pkg::res_t                res;
	tmpf_pkg::res_t                out_data;
	logic                          out_vld;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (tmpf_pkg::reg_idx_t'(cfg.index))
				tmpf_pkg::REG_GRID_COLUMNS: cfg_q.grid_columns <= cfg.data[7:0];
				tmpf_pkg::REG_GRID_ROWS:    cfg_q.grid_rows    <= cfg.data[7:0];
				tmpf_pkg::REG_ENTRY_COUNT:  cfg_q.entry_count  <= cfg.data;
				tmpf_pkg::REG_SLICE_LEFT:   cfg_q.slice_left   <= cfg.data[7:0];
				tmpf_pkg::REG_SLICE_TOP:    cfg_q.slice_top    <= cfg.data[7:0];
				tmpf_pkg::REG_SLICE_COLS:   cfg_q.slice_cols   <= cfg.data[7:0];
				tmpf_pkg::REG_SLICE_ROWS:   cfg_q.slice_rows   <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		req_pl.op          = tmpf_pkg::op_t'(req.op);
		req_pl.cell_number = req.cell_number;
		req_pl.tile_number = req.tile_number;
		req_pl.tile_px_x   = req.tile_px_x;
		req_pl.tile_px_y   = req.tile_px_y;
		req_pl.pixel_value = req.pixel_value;
		req_pl.out_x       = req.out_x;
		req_pl.out_y       = req.out_y;
	end

	assign req.ready = can_take;
	assign take      = req.valid && can_take;

	tmpf_addr u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (req_pl),
		.cfg    (cfg_q),
		.vld_s2 (vld_s2),
		.st_s2  (st_s2),
		.idx_s2 (idx_s2)
	);

	tmpf_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s2  (vld_s2),
		.st_s2   (st_s2),
		.idx_s2  (idx_s2),
		.count   (tmpf_pkg::live_count(cfg_q)),
		.res_vld (res_vld),
		.res     (res)
	);

	tmpf_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_vld),
		.push_data (res),
		.take_rd   (take && (req.op == tmpf_pkg::OP_READ)),
		.pop       (out_vld && rsp.ready),
		.can_take  (can_take),
		.out_vld   (out_vld),
		.out_data  (out_data)
	);

	assign rsp.valid       = out_vld;
	assign rsp.pixel_out   = out_data.pixel_out;
	assign rsp.covered     = out_data.covered;
	assign rsp.slice_valid = out_data.slice_valid;

endmodule

`default_nettype wire

[rtl/tmpf_addr.sv]
// Front stages: op decode, slice check and grid cell index multiply.
`default_nettype none

module tmpf_addr (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  tmpf_pkg::req_t               req,
	input  tmpf_pkg::cfg_t               cfg,
	output logic                         vld_s2,
	output tmpf_pkg::stage_t             st_s2,
	output logic [tmpf_pkg::IDX_W-1:0]   idx_s2
);

	logic [tmpf_pkg::GRID_W-1:0] gx;
	logic [tmpf_pkg::GRID_W-1:0] gy;
	logic                        in_slice;
	tmpf_pkg::stage_t            st_d;
	logic [tmpf_pkg::ROW_W-1:0]  row_d;
	logic [tmpf_pkg::ROW_W-1:0]  col_d;

	logic                        vld_s1;
	tmpf_pkg::stage_t            st_s1;
	logic [tmpf_pkg::ROW_W-1:0]  row_s1;
	logic [tmpf_pkg::ROW_W-1:0]  col_s1;

	always_comb begin
		gx = req.out_x[tmpf_pkg::COORD_W-1:tmpf_pkg::TILE_W];
		gy = req.out_y[tmpf_pkg::COORD_W-1:tmpf_pkg::TILE_W];
		in_slice = (16'(gx) < 16'(cfg.slice_cols)) && (16'(gy) < 16'(cfg.slice_rows));
		row_d = tmpf_pkg::ROW_W'(cfg.slice_top) + tmpf_pkg::ROW_W'(gy);
		col_d = tmpf_pkg::ROW_W'(cfg.slice_left) + tmpf_pkg::ROW_W'(gx);

		st_d.rd       = (req.op == tmpf_pkg::OP_READ);
		st_d.cell_we  = (req.op == tmpf_pkg::OP_CELL_WR) &&
			(32'(req.cell_number) < tmpf_pkg::MAX_ENTRIES);
		st_d.tile_we  = (req.op == tmpf_pkg::OP_TILE_WR) &&
			(32'(req.tile_number) < tmpf_pkg::MAX_ENTRIES) &&
			(32'(req.tile_px_x) < tmpf_pkg::TILE_DIM) &&
			(32'(req.tile_px_y) < tmpf_pkg::TILE_DIM);
		st_d.slice_ok = tmpf_pkg::slice_ok(cfg);
		st_d.look     = st_d.rd && st_d.slice_ok && in_slice;
		st_d.cell_addr   = tmpf_pkg::ENTRY_W'(req.cell_number);
		st_d.tile_number = req.tile_number;
		st_d.pixel_value = req.pixel_value;
		if (st_d.rd) begin
			st_d.px = req.out_x[tmpf_pkg::TILE_W-1:0];
			st_d.py = req.out_y[tmpf_pkg::TILE_W-1:0];
		end else begin
			st_d.px = tmpf_pkg::TILE_W'(req.tile_px_x);
			st_d.py = tmpf_pkg::TILE_W'(req.tile_px_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		st_s1  <= st_d;
		row_s1 <= row_d;
		col_s1 <= col_d;
		st_s2  <= st_s1;
		idx_s2 <= tmpf_pkg::IDX_W'(row_s1) * tmpf_pkg::IDX_W'(cfg.grid_columns) +
			tmpf_pkg::IDX_W'(col_s1);
	end

endmodule

`default_nettype wire

[rtl/tmpf_mem.sv]
// Cell store and tile store with their read-modify pipeline stages.
`default_nettype none

module tmpf_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld_s2,
	input  tmpf_pkg::stage_t            st_s2,
	input  logic [tmpf_pkg::IDX_W-1:0]  idx_s2,
	input  logic [tmpf_pkg::CNT_W-1:0]  count,
	output logic                        res_vld,
	output tmpf_pkg::res_t              res
);

	logic [tmpf_pkg::TNUM_W-1:0] cell_mem [tmpf_pkg::MAX_ENTRIES];
	logic [tmpf_pkg::PIX_W-1:0]  tile_mem [tmpf_pkg::TILE_DEPTH];

	logic                            cell_hit;
	logic                            vld_s3;
	tmpf_pkg::stage_t                st_s3;
	logic                            cell_hit_s3;
	logic [tmpf_pkg::TNUM_W-1:0]     cell_rd_s3;

	logic                            tile_hit;
	logic [tmpf_pkg::TNUM_W-1:0]     tile_sel;
	logic [tmpf_pkg::TILE_ADDR_W-1:0] tile_addr;

	logic                            vld_s4;
	logic                            covered_s4;
	logic                            sv_s4;
	logic [tmpf_pkg::PIX_W-1:0]      tile_rd_s4;

	assign cell_hit = st_s2.look && (idx_s2 < tmpf_pkg::IDX_W'(count));

	// cell store: writes and reads both happen at stage 2, in item order
	always_ff @(posedge clk) begin
		if (vld_s2 && st_s2.cell_we) begin
			cell_mem[st_s2.cell_addr] <= st_s2.tile_number;
		end
		cell_rd_s3 <= cell_mem[idx_s2[tmpf_pkg::ENTRY_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3 && st_s3.rd;
		end
	end

	always_ff @(posedge clk) begin
		st_s3       <= st_s2;
		cell_hit_s3 <= cell_hit;
	end

	always_comb begin
		tile_hit  = cell_hit_s3 && (cell_rd_s3 < tmpf_pkg::TNUM_W'(count));
		tile_sel  = st_s3.tile_we ? st_s3.tile_number : cell_rd_s3;
		tile_addr = {tmpf_pkg::ENTRY_W'(tile_sel), st_s3.py, st_s3.px};
	end

	// tile store: writes and reads both happen at stage 3
	always_ff @(posedge clk) begin
		if (vld_s3 && st_s3.tile_we) begin
			tile_mem[tile_addr] <= st_s3.pixel_value;
		end
		tile_rd_s4 <= tile_mem[tile_addr];
		covered_s4 <= tile_hit;
		sv_s4      <= st_s3.slice_ok;
	end

	always_comb begin
		res_vld         = vld_s4;
		res.covered     = covered_s4;
		res.slice_valid = sv_s4;
		res.pixel_out   = covered_s4 ? tile_rd_s4 : '0;
	end

	a_res_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> $past(vld_s2, 2))
		else $error("result without an item two stages back");
	a_cover_needs_slice: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && covered_s4 |-> sv_s4)
		else $error("covered pixel from an invalid slice");

endmodule

`default_nettype wire

[rtl/tmpf_ofifo.sv]
// Result queue with credit count that throttles request acceptance.
`default_nettype none

module tmpf_ofifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tmpf_pkg::res_t  push_data,
	input  logic            take_rd,
	input  logic            pop,
	output logic            can_take,
	output logic            out_vld,
	output tmpf_pkg::res_t  out_data
);

	tmpf_pkg::res_t              q_mem [tmpf_pkg::FIFO_DEPTH];
	logic [tmpf_pkg::PTR_W-1:0]  wr_ptr_q;
	logic [tmpf_pkg::PTR_W-1:0]  rd_ptr_q;
	logic [tmpf_pkg::CRD_W-1:0]  cnt_q;
	logic [tmpf_pkg::CRD_W-1:0]  pend_q;

	assign can_take = (32'(pend_q) < tmpf_pkg::FIFO_DEPTH);
	assign out_vld  = (cnt_q != '0);
	assign out_data = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			pend_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + tmpf_pkg::PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tmpf_pkg::PTR_W'(1);
			end
			cnt_q  <= cnt_q + tmpf_pkg::CRD_W'(push) - tmpf_pkg::CRD_W'(pop);
			pend_q <= pend_q + tmpf_pkg::CRD_W'(take_rd) - tmpf_pkg::CRD_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (32'(cnt_q) < tmpf_pkg::FIFO_DEPTH) || pop)
		else $error("result queue overflow");
	a_credit_covers: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q >= cnt_q)
		else $error("queued results exceed outstanding reads");

endmodule

`default_nettype wire

[verif/tb_tile_map_pixel_fetch.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the tile-map pixel fetch block: random cell, tile and read beats.

module tb_tile_map_pixel_fetch;
	import tmpf_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int ITEM_GOAL     = 1500;
	localparam int SETTLE_CYCLES = 10;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	class pixel_scoreboard;
		cfg_t              regs;
		logic [TNUM_W-1:0] cell_mem [MAX_ENTRIES];
		logic [PIX_W-1:0]  tile_mem [TILE_DEPTH];
		res_t              pending_pixels [$];
		int                failures;

		function new();
			regs = '0;
			failures = 0;
		endfunction

		static function bit slice_open(cfg_t c);
			int unsigned right;
			int unsigned bottom;
			right = c.slice_left + c.slice_cols;
			bottom = c.slice_top + c.slice_rows;
			return c.slice_cols != 0 && c.slice_rows != 0 &&
				right <= c.grid_columns && bottom <= c.grid_rows;
		endfunction

		static function int unsigned live_entries(cfg_t c);
			return (c.entry_count > MAX_ENTRIES) ? MAX_ENTRIES : c.entry_count;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GRID_COLUMNS: regs.grid_columns = data[CFG8_W-1:0];
				REG_GRID_ROWS:    regs.grid_rows = data[CFG8_W-1:0];
				REG_ENTRY_COUNT:  regs.entry_count = data;
				REG_SLICE_LEFT:   regs.slice_left = data[CFG8_W-1:0];
				REG_SLICE_TOP:    regs.slice_top = data[CFG8_W-1:0];
				REG_SLICE_COLS:   regs.slice_cols = data[CFG8_W-1:0];
				REG_SLICE_ROWS:   regs.slice_rows = data[CFG8_W-1:0];
				default: ;
			endcase
		endfunction

		function res_t predict_pixel(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy);
			res_t        want;
			int unsigned gx;
			int unsigned gy;
			int unsigned idx;
			int unsigned tnum;
			int unsigned live;
			want = '0;
			want.slice_valid = slice_open(regs);
			gx = ox / TILE_DIM;
			gy = oy / TILE_DIM;
			live = live_entries(regs);
			if (want.slice_valid && gx < regs.slice_cols && gy < regs.slice_rows) begin
				idx = (regs.slice_top + gy) * regs.grid_columns + regs.slice_left + gx;
				if (idx < live) begin
					tnum = cell_mem[idx];
					if (tnum < live) begin
						want.pixel_out = tile_mem[tnum * TILE_DIM * TILE_DIM +
							(oy % TILE_DIM) * TILE_DIM + ox % TILE_DIM];
						want.covered = 1'b1;
					end
				end
			end
			return want;
		endfunction

		function void note_request(req_t r);
			case (r.op)
				OP_CELL_WR: cell_mem[r.cell_number] = r.tile_number;
				OP_TILE_WR: begin
					if (r.tile_number < MAX_ENTRIES)
						tile_mem[r.tile_number * TILE_DIM * TILE_DIM +
							r.tile_px_y * TILE_DIM + r.tile_px_x] = r.pixel_value;
				end
				OP_READ: pending_pixels.push_back(predict_pixel(r.out_x, r.out_y));
				default: ;
			endcase
		endfunction

		function void check_pixel(res_t got);
			res_t want;
			if (pending_pixels.size() == 0) begin
				$error("result beat with no read outstanding");
				failures++;
				return;
			end
			want = pending_pixels.pop_front();
			if (got.pixel_out !== want.pixel_out) begin
				$error("pixel_out: expected %0d, actual %0d", want.pixel_out, got.pixel_out);
				failures++;
			end
			if (got.covered !== want.covered) begin
				$error("covered: expected %0d, actual %0d", want.covered, got.covered);
				failures++;
			end
			if (got.slice_valid !== want.slice_valid) begin
				$error("slice_valid: expected %0d, actual %0d", want.slice_valid,
					got.slice_valid);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tmpf_cfg_if cfg_if ();
	tmpf_in_if  req_if ();
	tmpf_out_if rsp_if ();

	tile_map_pixel_fetch dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	pixel_scoreboard   sb = new();
	cfg_t              cur_cfg = '0;
	bit                cell_set [MAX_ENTRIES];
	logic [TNUM_W-1:0] cell_val [MAX_ENTRIES];
	int unsigned       px_list [MAX_ENTRIES][$];
	int                useful_items = 0;
	int                cycle_count = 0;
	int                rsp_stall = 0;
	bit                req_calm = 1'b0;
	bit                rsp_calm = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int pick_gap(inout bit calm);
		if ($urandom_range(0, 47) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	// accepted beats feed the scoreboard
	always @(posedge clk) begin
		if (arst_n && cfg_if.valid && cfg_if.ready)
			sb.write_reg(cfg_if.index, cfg_if.data);
		if (arst_n && req_if.valid && req_if.ready)
			sb.note_request(req_t'{op_t'(req_if.op), req_if.cell_number, req_if.tile_number,
				req_if.tile_px_x, req_if.tile_px_y, req_if.pixel_value,
				req_if.out_x, req_if.out_y});
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			sb.check_pixel(res_t'{rsp_if.pixel_out, rsp_if.covered, rsp_if.slice_valid});
			rsp_stall = pick_gap(rsp_calm);
		end
		if (rsp_stall > 0) begin
			rsp_if.ready <= 1'b0;
			rsp_stall--;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	function automatic req_t noise_req();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	function automatic cfg_t mk_cfg(int unsigned gc, int unsigned gr, int unsigned cnt,
			int unsigned left, int unsigned top, int unsigned cols, int unsigned rows);
		cfg_t c;
		c.grid_columns = CFG8_W'(gc);
		c.grid_rows = CFG8_W'(gr);
		c.entry_count = CNT_W'(cnt);
		c.slice_left = CFG8_W'(left);
		c.slice_top = CFG8_W'(top);
		c.slice_cols = CFG8_W'(cols);
		c.slice_rows = CFG8_W'(rows);
		return c;
	endfunction

	task automatic send_beat(input req_t r);
		int gap;
		gap = pick_gap(req_calm);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op <= r.op;
		req_if.cell_number <= r.cell_number;
		req_if.tile_number <= r.tile_number;
		req_if.tile_px_x <= r.tile_px_x;
		req_if.tile_px_y <= r.tile_px_y;
		req_if.pixel_value <= r.pixel_value;
		req_if.out_x <= r.out_x;
		req_if.out_y <= r.out_y;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		case (r.op)
			OP_CELL_WR: begin
				cell_set[r.cell_number] = 1'b1;
				cell_val[r.cell_number] = r.tile_number;
				useful_items++;
			end
			OP_TILE_WR: begin
				if (r.tile_number < MAX_ENTRIES) begin
					px_list[r.tile_number].push_back({r.tile_px_y, r.tile_px_x});
					useful_items++;
				end
			end
			OP_READ: useful_items++;
			default: ;
		endcase
	endtask

	task automatic cell_wr(input int unsigned idx, input int unsigned tnum);
		req_t r;
		r = noise_req();
		r.op = OP_CELL_WR;
		r.cell_number = CELL_W'(idx);
		r.tile_number = TNUM_W'(tnum);
		send_beat(r);
	endtask

	task automatic tile_wr(input int unsigned tnum, input int unsigned px, input int unsigned py,
			input int unsigned val);
		req_t r;
		r = noise_req();
		r.op = OP_TILE_WR;
		r.tile_number = TNUM_W'(tnum);
		r.tile_px_x = PXC_W'(px);
		r.tile_px_y = PXC_W'(py);
		r.pixel_value = PIX_W'(val);
		send_beat(r);
	endtask

	task automatic read_px(input int unsigned ox, input int unsigned oy);
		req_t r;
		r = noise_req();
		r.op = OP_READ;
		r.out_x = COORD_W'(ox);
		r.out_y = COORD_W'(oy);
		send_beat(r);
	endtask

	// well-formed chain: make sure the cell and a tile pixel exist, then read it
	task automatic read_chain();
		int unsigned gx;
		int unsigned gy;
		int unsigned idx;
		int unsigned live;
		int unsigned tnum;
		int unsigned spot;
		gx = $urandom_range(0, cur_cfg.slice_cols - 1);
		gy = $urandom_range(0, cur_cfg.slice_rows - 1);
		idx = (cur_cfg.slice_top + gy) * cur_cfg.grid_columns + cur_cfg.slice_left + gx;
		live = pixel_scoreboard::live_entries(cur_cfg);
		spot = $urandom_range(0, TILE_DIM * TILE_DIM - 1);
		if (idx < live) begin
			if (!cell_set[idx] || $urandom_range(0, 4) == 0)
				cell_wr(idx, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) :
					$urandom_range(0, live - 1));
			tnum = cell_val[idx];
			if (tnum < live) begin
				if (px_list[tnum].size() == 0 || $urandom_range(0, 2) == 0)
					tile_wr(tnum, $urandom_range(0, 31), $urandom_range(0, 31),
						$urandom_range(0, 255));
				spot = px_list[tnum][$urandom_range(0, px_list[tnum].size() - 1)];
			end
		end
		read_px(gx * TILE_DIM + spot % TILE_DIM, gy * TILE_DIM + spot / TILE_DIM);
	endtask

	// any coordinate; pushed out of the slice so no blank entry is looked up
	task automatic wild_read();
		req_t r;
		r = noise_req();
		r.op = OP_READ;
		if (pixel_scoreboard::slice_open(cur_cfg) && r.out_x / TILE_DIM < cur_cfg.slice_cols &&
				r.out_y / TILE_DIM < cur_cfg.slice_rows)
			r.out_x[COORD_W-1:TILE_W] = '1;
		send_beat(r);
	endtask

	task automatic noise_beat();
		req_t r;
		r = noise_req();
		case ($urandom_range(0, 2))
			0: r.op = OP_CELL_WR;
			1: begin
				r.op = OP_TILE_WR;
				if ($urandom_range(0, 2) == 0)
					r.tile_number[TNUM_W-1:ENTRY_W] = '0;
			end
			default: r.op = op_t'(OP_NONE);
		endcase
		send_beat(r);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
	endtask

	// 8-bit registers get a random ninth bit that must be dropped
	task automatic program_regs(input cfg_t c, input bit poke_unused);
		put_reg(REG_GRID_COLUMNS, {1'($urandom), c.grid_columns});
		put_reg(REG_GRID_ROWS, {1'($urandom), c.grid_rows});
		put_reg(REG_ENTRY_COUNT, c.entry_count);
		put_reg(REG_SLICE_LEFT, {1'($urandom), c.slice_left});
		put_reg(REG_SLICE_TOP, {1'($urandom), c.slice_top});
		put_reg(REG_SLICE_COLS, {1'($urandom), c.slice_cols});
		put_reg(REG_SLICE_ROWS, {1'($urandom), c.slice_rows});
		if (poke_unused)
			put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_if.valid <= 1'b0;
		cur_cfg = c;
	endtask

	task automatic run_phase(input int quota);
		int start;
		int pick;
		bit open;
		start = useful_items;
		open = pixel_scoreboard::slice_open(cur_cfg);
		while (useful_items - start < quota) begin
			pick = $urandom_range(0, 9);
			if (open && pick < 6)
				read_chain();
			else if (pick < 8)
				noise_beat();
			else
				wild_read();
		end
		drain();
	endtask

	task automatic directed_items();
		req_t r;
		cell_wr(0, 5);
		cell_wr(255, 16'hFFFF);
		cell_wr(17, 255);
		cell_wr(1, 0);
		tile_wr(5, 0, 0, 8'hA5);
		tile_wr(5, 31, 31, 8'hFF);
		tile_wr(255, 31, 0, 8'h5A);
		tile_wr(0, 16, 16, 8'h3C);
		tile_wr(256, 1, 1, 8'h77);
		tile_wr(16'hFFFF, 31, 31, 8'h11);
		r = '1;
		send_beat(r);
		read_px(0, 0);
		read_px(31, 31);
		read_px(63, 32);
		read_px(48, 16);
		read_px(480, 480);
		read_px(8191, 8191);
		read_px(0, 8191);
		// rewrite a cell and read through it right behind the write
		cell_wr(0, 255);
		read_px(31, 0);
	endtask

	initial begin
		cfg_t        c;
		int unsigned gc;
		int unsigned gr;
		int unsigned cols;
		int unsigned rows;
		int unsigned cnt;
		req_if.valid = 1'b0;
		req_if.op = OP_CELL_WR;
		req_if.cell_number = '0;
		req_if.tile_number = '0;
		req_if.tile_px_x = '0;
		req_if.tile_px_y = '0;
		req_if.pixel_value = '0;
		req_if.out_x = '0;
		req_if.out_y = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		rsp_if.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		repeat (4) wild_read();
		drain();

		program_regs(mk_cfg(16, 16, 256, 0, 0, 16, 16), 1'b0);
		directed_items();
		run_phase(130);
		program_regs(mk_cfg(255, 255, 511, 0, 0, 255, 255), 1'b0);
		run_phase(120);
		program_regs(mk_cfg(8, 4, 20, 3, 1, 5, 3), 1'b0);
		run_phase(150);
		program_regs(mk_cfg(255, 255, 300, 200, 0, 100, 10), 1'b1);
		run_phase(30);
		program_regs(mk_cfg(0, 0, 0, 0, 0, 0, 0), 1'b1);
		run_phase(30);
		program_regs(mk_cfg(1, 1, 1, 0, 0, 1, 1), 1'b0);
		run_phase(60);
		program_regs(mk_cfg(255, 255, 256, 254, 254, 1, 1), 1'b0);
		run_phase(60);

		while (useful_items < ITEM_GOAL) begin
			if ($urandom_range(0, 7) == 0) begin
				c = mk_cfg($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 511), $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255));
			end else begin
				gc = $urandom_range(1, 24);
				gr = $urandom_range(1, 24);
				cols = $urandom_range(1, gc);
				rows = $urandom_range(1, gr);
				cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(257, 511) :
					$urandom_range(0, (gc * gr < 256) ? gc * gr + 4 : 256);
				c = mk_cfg(gc, gr, cnt, $urandom_range(0, gc - cols),
					$urandom_range(0, gr - rows), cols, rows);
			end
			program_regs(c, $urandom_range(0, 3) == 0);
			run_phase(120);
		end

		drain();
		if (sb.failures == 0 && sb.pending_pixels.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/tmpf_pkg.sv
rtl/tmpf_if.sv
rtl/tmpf_addr.sv
rtl/tmpf_mem.sv
rtl/tmpf_ofifo.sv
rtl/tile_map_pixel_fetch.sv
verif/tb_tile_map_pixel_fetch.sv
